// ===== rtl/assert_macros.svh =====
// Assertion macros used by the checker file.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is held.
`define GMPE_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication form: antecedent in the same cycle as the consequent.
`define GMPE_ASSERT_IMP(label, ante, cons, msg) \
  `GMPE_ASSERT(label, (ante) |-> (cons), msg)

// Implication form: consequent in the cycle after the antecedent.
`define GMPE_ASSERT_NXT(label, ante, cons, msg) \
  `GMPE_ASSERT(label, (ante) |=> (cons), msg)

`endif

// ===== rtl/gmpe_pkg.sv =====
// Shared types and constants for the grid max-path energy core.
// No dependencies; imported by the core, line, cell and score modules.
`timescale 1ns / 1ps
`default_nettype none

package gmpe_pkg;

  localparam int unsigned CFG_W   = 6;
  localparam int unsigned VAL_W   = 16;
  localparam int unsigned SCORE_W = 32;
  localparam int unsigned DIFF_W  = SCORE_W + 2;

  localparam logic [CFG_W-1:0]        GRID_SIZE_RST = 6'd32;
  localparam logic signed [VAL_W-1:0] CELL_BLOCKED  = -16'sd1;

  typedef struct packed {
    logic signed [VAL_W-1:0] cell_value;
    logic signed [VAL_W-1:0] cost_from_left;
    logic signed [VAL_W-1:0] cost_from_above;
  } cell_in_t;

  typedef struct packed {
    logic signed [SCORE_W-1:0] final_score;
    logic                      unreachable;
  } result_t;

  // One line buffer entry: reach flag and score.
  typedef struct packed {
    logic                      reach;
    logic signed [SCORE_W-1:0] score;
  } entry_t;

  typedef struct packed {
    logic is_start;
    logic has_left;
    logic has_up;
  } flags_t;

endpackage

`default_nettype wire

// ===== rtl/gmpe_stream_if.sv =====
// Valid/ready stream channel with a typed payload.
// Depends on nothing; payload type set per instance.
`timescale 1ns / 1ps
`default_nettype none

interface gmpe_stream_if #(
  parameter type data_t = logic
) ();
  logic  valid;
  logic  ready;
  data_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/grid_max_path_energy_dp_core.sv =====
// Grid max-path energy core: cells of a square grid arrive in raster order, one
// transfer per cell on cell_i; one clock per cell is sustained unless the last cell
// of a grid waits for a result still on res_o. Each transfer is registered once,
// scored in the next cycle against the left score and the row above (held in a
// chain of MAX_GRID line cells); the last cell of a grid puts one result on res_o.
// The output register lets the next grid start while a result waits. grid_size
// (0 acts as 1, above MAX_GRID acts as MAX_GRID) may only change between grids.
`timescale 1ns / 1ps
`default_nettype none

module grid_max_path_energy_dp_core #(
  parameter int unsigned MAX_GRID = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [gmpe_pkg::CFG_W-1:0]  cfg_wdata_i,
  gmpe_stream_if.sink                 cell_i,
  gmpe_stream_if.source               res_o
);
  import gmpe_pkg::*;

  localparam int unsigned IW = (MAX_GRID > 1) ? $clog2(MAX_GRID) : 1;
  localparam int unsigned SW = ($clog2(MAX_GRID + 1) > CFG_W) ?
                               $clog2(MAX_GRID + 1) : CFG_W;
  localparam logic [SW-1:0] MaxSize = SW'(MAX_GRID);

  logic [CFG_W-1:0] grid_size_q;
  logic [IW-1:0]    col_q, col_d;
  logic [IW-1:0]    row_q, row_d;

  logic [SW-1:0]    size_w;
  logic [SW-1:0]    lim_w;
  logic [IW-1:0]    lim;
  logic [IW-1:0]    col_c, row_c;
  logic             last_col, last_row;
  logic             in_xfer;

  cell_in_t         b_cell_q;
  logic [IW-1:0]    b_col_q;
  flags_t           b_flags_q;
  entry_t           b_up_q;
  logic             b_last_q;
  logic             b_vld_q;
  logic             b_fire;

  entry_t           left_q;
  entry_t           up_rd;
  entry_t           res;
  flags_t           flags;

  logic             out_vld_q;
  result_t          out_q;

  // Position of the incoming cell, clamped to the grid in use.
  always_comb begin
    size_w = SW'(grid_size_q);
    if (grid_size_q == '0) begin
      size_w = SW'(1);
    end else if (size_w > MaxSize) begin
      size_w = MaxSize;
    end
    lim_w    = size_w - SW'(1);
    lim      = IW'(lim_w);
    col_c    = (SW'(col_q) > lim_w) ? lim : col_q;
    row_c    = (SW'(row_q) > lim_w) ? lim : row_q;
    last_col = (col_c == lim);
    last_row = (row_c == lim);

    if (last_col) begin
      col_d = '0;
      row_d = last_row ? '0 : row_c + IW'(1);
    end else begin
      col_d = col_c + IW'(1);
      row_d = row_c;
    end

    flags.is_start = (row_c == '0) && (col_c == '0);
    flags.has_left = (col_c != '0);
    flags.has_up   = (row_c != '0);
  end

  assign b_fire       = b_vld_q && (!b_last_q || !out_vld_q || res_o.ready);
  assign cell_i.ready = !b_vld_q || b_fire;
  assign in_xfer      = cell_i.valid && cell_i.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_size_q <= GRID_SIZE_RST;
    end else if (cfg_we_i) begin
      grid_size_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      b_vld_q <= 1'b0;
    end else begin
      if (in_xfer) begin
        col_q <= col_d;
        row_q <= row_d;
      end
      if (in_xfer) begin
        b_vld_q <= 1'b1;
      end else if (b_fire) begin
        b_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_xfer) begin
      b_cell_q  <= cell_i.data;
      b_col_q   <= col_c;
      b_flags_q <= flags;
      b_up_q    <= up_rd;
      b_last_q  <= last_col && last_row;
    end
  end

  gmpe_line #(
    .DEPTH (MAX_GRID),
    .IW    (IW)
  ) u_line (
    .clk_i     (clk_i),
    .wr_en_i   (b_fire),
    .wr_col_i  (b_col_q),
    .wr_data_i (res),
    .rd_col_i  (col_c),
    .rd_data_o (up_rd)
  );

  gmpe_score u_score (
    .cell_i  (b_cell_q),
    .left_i  (left_q),
    .up_i    (b_up_q),
    .flags_i (b_flags_q),
    .res_o   (res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q    <= '0;
      out_vld_q <= 1'b0;
    end else begin
      if (b_fire) begin
        left_q <= res;
      end
      if (b_fire && b_last_q) begin
        out_vld_q <= 1'b1;
      end else if (res_o.ready) begin
        out_vld_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (b_fire && b_last_q) begin
      out_q.final_score <= res.score;
      out_q.unreachable <= !res.reach;
    end
  end

  assign res_o.valid = out_vld_q;
  assign res_o.data  = out_q;

endmodule

`default_nettype wire

// ===== rtl/gmpe_cell.sv =====
// One line buffer cell: holds the score of one column of the row above.
// Read data is OR-ed into the chain coming from the next cell. Uses gmpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gmpe_cell #(
  parameter int unsigned IW  = 5,
  parameter int unsigned IDX = 0
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [IW-1:0]     wr_col_i,
  input  gmpe_pkg::entry_t  wr_data_i,
  input  logic [IW-1:0]     rd_col_i,
  input  gmpe_pkg::entry_t  rd_chain_i,
  output gmpe_pkg::entry_t  rd_chain_o
);
  import gmpe_pkg::*;

  localparam logic [IW-1:0] Idx = IW'(IDX);

  entry_t entry_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_col_i == Idx)) begin
      entry_q <= wr_data_i;
    end
  end

  assign rd_chain_o = rd_chain_i | ((rd_col_i == Idx) ? entry_q : '0);

endmodule

`default_nettype wire

// ===== rtl/gmpe_line.sv =====
// Line buffer built as a row of gmpe_cell instances, one per column.
// Depends on gmpe_pkg and gmpe_cell.
`timescale 1ns / 1ps
`default_nettype none

module gmpe_line #(
  parameter int unsigned DEPTH = 32,
  parameter int unsigned IW    = 5
) (
  input  logic              clk_i,
  input  logic              wr_en_i,
  input  logic [IW-1:0]     wr_col_i,
  input  gmpe_pkg::entry_t  wr_data_i,
  input  logic [IW-1:0]     rd_col_i,
  output gmpe_pkg::entry_t  rd_data_o
);
  import gmpe_pkg::*;

  entry_t chain [DEPTH+1];

  assign chain[DEPTH] = '0;

  for (genvar k = 0; k < DEPTH; k++) begin : g_cell
    gmpe_cell #(
      .IW  (IW),
      .IDX (k)
    ) u_cell (
      .clk_i      (clk_i),
      .wr_en_i    (wr_en_i),
      .wr_col_i   (wr_col_i),
      .wr_data_i  (wr_data_i),
      .rd_col_i   (rd_col_i),
      .rd_chain_i (chain[k+1]),
      .rd_chain_o (chain[k])
    );
  end

  assign rd_data_o = chain[0];

endmodule

`default_nettype wire

// ===== rtl/gmpe_score.sv =====
// Score update for one cell: best allowed move from left or above plus gain.
// Depends on gmpe_pkg.
`timescale 1ns / 1ps
`default_nettype none

module gmpe_score (
  input  gmpe_pkg::cell_in_t cell_i,
  input  gmpe_pkg::entry_t   left_i,
  input  gmpe_pkg::entry_t   up_i,
  input  gmpe_pkg::flags_t   flags_i,
  output gmpe_pkg::entry_t   res_o
);
  import gmpe_pkg::*;

  logic signed [DIFF_W-1:0]  left_rem;
  logic signed [DIFF_W-1:0]  up_rem;
  logic signed [DIFF_W-1:0]  best;
  logic                      have_left;
  logic                      have_up;
  logic                      take_up;
  logic                      reach;
  logic signed [SCORE_W-1:0] score;

  always_comb begin
    left_rem  = DIFF_W'(left_i.score) - DIFF_W'(cell_i.cost_from_left);
    up_rem    = DIFF_W'(up_i.score) - DIFF_W'(cell_i.cost_from_above);
    have_left = flags_i.has_left && left_i.reach;
    have_up   = flags_i.has_up && up_i.reach;
    take_up   = have_up && (!have_left || (up_rem > left_rem));
    best      = take_up ? up_rem : left_rem;

    if (flags_i.is_start) begin
      reach = 1'b1;
      score = SCORE_W'(cell_i.cell_value);
    end else if ((cell_i.cell_value != CELL_BLOCKED) && (have_left || have_up) &&
                 !best[DIFF_W-1]) begin
      reach = 1'b1;
      score = best[SCORE_W-1:0] + SCORE_W'(cell_i.cell_value);
    end else begin
      reach = 1'b0;
      score = '0;
    end

    res_o.reach = reach;
    res_o.score = score;
  end

endmodule

`default_nettype wire

// ===== rtl/gmpe_checker.sv =====
// Port-level checks for grid_max_path_energy_dp_core, attached by bind.
// Depends on assert_macros.svh.
`timescale 1ns / 1ps
`default_nettype none
`include "assert_macros.svh"

module gmpe_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] final_score_i,
  input logic        unreachable_i
);

  `GMPE_ASSERT_NXT(a_out_hold, out_valid_i && !out_ready_i, out_valid_i, "result dropped before transfer")
  `GMPE_ASSERT_NXT(a_out_stable, out_valid_i && !out_ready_i, $stable(final_score_i) && $stable(unreachable_i), "result changed while stalled")
  `GMPE_ASSERT_IMP(a_unreach_zero, out_valid_i && unreachable_i, final_score_i == '0, "unreachable result with nonzero score")
  `GMPE_ASSERT_IMP(a_rise_after_in, $rose(out_valid_i), $past(in_valid_i && in_ready_i, 2), "result without a cell transfer two cycles before")

endmodule

bind grid_max_path_energy_dp_core gmpe_checker u_gmpe_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .in_valid_i    (cell_i.valid),
  .in_ready_i    (cell_i.ready),
  .out_valid_i   (res_o.valid),
  .out_ready_i   (res_o.ready),
  .final_score_i (res_o.data.final_score),
  .unreachable_i (res_o.data.unreachable)
);

`default_nettype wire
